// ===== rtl/core/bxavg_pkg.sv =====
package bxavg_pkg;

  // fixed field and register widths
  localparam int PIXEL_W      = 8;
  localparam int SUM_W        = 14;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;
  localparam int SCALE_MODE_W = 2;
  localparam int LG_W         = 2;
  localparam int MASK_W       = 3;

  // defaults for the top level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // register reset values
  localparam logic [SCALE_MODE_W-1:0] RST_SCALE_MODE    = 2'd0;
  localparam logic [CFG_DATA_W-1:0]   RST_SOURCE_WIDTH  = 11'd1024;
  localparam logic [CFG_DATA_W-1:0]   RST_SOURCE_HEIGHT = 11'd1024;

  // output beat buffer
  localparam int OUT_FIFO_DEPTH = 3;
  localparam int FIFO_LVL_W     = $clog2(OUT_FIFO_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_MODE    = 2'd0,
    CFG_SOURCE_WIDTH  = 2'd1,
    CFG_SOURCE_HEIGHT = 2'd2
  } cfg_reg_t;

  // block size codes, codes 2 and 3 both act as 8x8
  localparam logic [SCALE_MODE_W-1:0] SCALE_2X = 2'd0;
  localparam logic [SCALE_MODE_W-1:0] SCALE_4X = 2'd1;

  // rounding terms, half the pixel count of a block
  localparam logic [SUM_W:0] ROUND_2X = 15'd2;
  localparam logic [SUM_W:0] ROUND_4X = 15'd8;
  localparam logic [SUM_W:0] ROUND_8X = 15'd32;

  // one result beat
  typedef struct packed {
    logic               eof;
    logic               eor;
    logic [PIXEL_W-1:0] pixel;
  } out_beat_t;

  // log2 of the block edge
  function automatic logic [LG_W-1:0] block_log2(input logic [SCALE_MODE_W-1:0] mode);
    logic [LG_W-1:0] lg;
    case (mode)
      SCALE_2X: lg = 2'd1;
      SCALE_4X: lg = 2'd2;
      default:  lg = 2'd3;
    endcase
    return lg;
  endfunction

  // block edge minus one, used as a position mask
  function automatic logic [MASK_W-1:0] block_mask(input logic [LG_W-1:0] lg);
    logic [MASK_W-1:0] m;
    case (lg)
      2'd1:    m = 3'd1;
      2'd2:    m = 3'd3;
      default: m = 3'd7;
    endcase
    return m;
  endfunction

  // rounded mean of a block sum
  function automatic logic [PIXEL_W-1:0] block_mean(input logic [SUM_W-1:0] sum,
                                                    input logic [LG_W-1:0]  lg);
    logic [SUM_W:0]     t;
    logic [PIXEL_W-1:0] m;
    case (lg)
      2'd1: begin
        t = {1'b0, sum} + ROUND_2X;
        m = t[9:2];
      end
      2'd2: begin
        t = {1'b0, sum} + ROUND_4X;
        m = t[11:4];
      end
      default: begin
        t = {1'b0, sum} + ROUND_8X;
        m = t[13:6];
      end
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/box_average_downscale_top.sv =====
// result path: the pixel that closes a block has its slot read at the accepting edge, then is
//   added, written back and averaged, and its beat is registered into the beat buffer
// throughput: one pixel per cycle while in_tready is high, set by the read-add-write loop
//   on the column accumulator memory, with forwarding for back-to-back hits on one slot
// reset: synchronous rst_n clears position counters, pipeline and beat buffer and loads
//   the register defaults; the accumulator memory is not cleared, each band overwrites it
module box_average_downscale_top #(
  parameter int MAX_WIDTH  = bxavg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bxavg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: in_pixel[7:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,
  // out_tdata: out_pixel[7:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,
  output logic                              out_tlast,
  // out_tuser: end_of_frame[0]
  output logic                              out_tuser,
  input  logic                              cfg_we,
  input  logic [bxavg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bxavg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import bxavg_pkg::*;

  localparam int SLOT_COUNT = MAX_WIDTH / 2;
  localparam int AW  = $clog2(SLOT_COUNT);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WXW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ? $clog2(MAX_WIDTH + 1)
                                                            : CFG_DATA_W;
  localparam int HXW = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ? $clog2(MAX_HEIGHT + 1)
                                                             : CFG_DATA_W;

  // configuration registers
  logic [SCALE_MODE_W-1:0] scale_mode_r;
  logic [CFG_DATA_W-1:0]   source_width_r;
  logic [CFG_DATA_W-1:0]   source_height_r;

  // source position
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // accept stage signals
  logic              accept;
  logic [LG_W-1:0]   lg;
  logic [MASK_W-1:0] nm1;
  logic [WXW-1:0]    n_w, w_lo, w_hi, w_eff, col_inc;
  logic [HXW-1:0]    n_h, h_lo, h_hi, h_eff, row_inc;
  logic              row_end, frame_end;
  logic [MASK_W-1:0] cin, rin;
  logic              blk_first, blk_last;
  logic [CW-1:0]     slot_full;
  logic              slot_ok;

  // update stage registers
  logic               s1_vld_r;
  logic [PIXEL_W-1:0] s1_pix_r;
  logic [AW-1:0]      s1_slot_r;
  logic               s1_ok_r;
  logic               s1_first_r;
  logic               s1_last_r;
  logic               s1_eor_r;
  logic               s1_eof_r;
  logic [LG_W-1:0]    s1_lg_r;

  // last write, for forwarding
  logic             wr_vld_r;
  logic [AW-1:0]    wr_addr_r;
  logic [SUM_W-1:0] wr_data_r;

  logic                  ram_we;
  logic [SUM_W-1:0]      ram_rdata;
  logic                  fwd;
  logic [SUM_W-1:0]      base;
  logic [SUM_W-1:0]      sum_new;
  logic                  push;
  out_beat_t             push_beat;
  out_beat_t             out_beat;
  logic [FIFO_LVL_W-1:0] fifo_level;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r    <= RST_SCALE_MODE;
      source_width_r  <= RST_SOURCE_WIDTH;
      source_height_r <= RST_SOURCE_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE_MODE:    scale_mode_r    <= cfg_wdata[SCALE_MODE_W-1:0];
        CFG_SOURCE_WIDTH:  source_width_r  <= cfg_wdata;
        CFG_SOURCE_HEIGHT: source_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // block size and frame size in effect
  always_comb begin
    lg    = block_log2(scale_mode_r);
    nm1   = block_mask(lg);
    n_w   = WXW'(nm1) + WXW'(1);
    w_lo  = (WXW'(source_width_r) < n_w) ? n_w : WXW'(source_width_r);
    w_hi  = (w_lo > WXW'(MAX_WIDTH)) ? WXW'(MAX_WIDTH) : w_lo;
    w_eff = w_hi & ~WXW'(nm1);
    n_h   = HXW'(nm1) + HXW'(1);
    h_lo  = (HXW'(source_height_r) < n_h) ? n_h : HXW'(source_height_r);
    h_hi  = (h_lo > HXW'(MAX_HEIGHT)) ? HXW'(MAX_HEIGHT) : h_lo;
    h_eff = h_hi & ~HXW'(nm1);
  end

  // position decode of the incoming pixel
  always_comb begin
    col_inc   = WXW'(col_r) + WXW'(1);
    row_inc   = HXW'(row_r) + HXW'(1);
    row_end   = (col_inc >= w_eff);
    frame_end = row_end && (row_inc >= h_eff);
    cin       = col_r[MASK_W-1:0] & nm1;
    rin       = row_r[MASK_W-1:0] & nm1;
    blk_first = (cin == '0) && (rin == '0);
    blk_last  = (cin == nm1) && (rin == nm1);
    slot_full = col_r >> lg;
    slot_ok   = (slot_full < CW'(SLOT_COUNT));
  end

  // room for every beat still in flight
  assign in_tready = ({1'b0, fifo_level} + (FIFO_LVL_W + 1)'(s1_vld_r))
                     < (FIFO_LVL_W + 1)'(OUT_FIFO_DEPTH);
  assign accept    = in_tvalid & in_tready;

  // next position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // accept stage to update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_tdata;
      s1_slot_r  <= slot_full[AW-1:0];
      s1_ok_r    <= slot_ok;
      s1_first_r <= blk_first;
      s1_last_r  <= blk_last;
      s1_eor_r   <= row_end;
      s1_eof_r   <= frame_end;
      s1_lg_r    <= lg;
    end
  end

  // column accumulator line
  bxavg_ram #(
    .WIDTH (SUM_W),
    .DEPTH (SLOT_COUNT)
  ) u_band_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_slot_r),
    .wdata (sum_new),
    .re    (accept),
    .raddr (slot_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  // read-add-write with forwarding of the previous cycle's write
  always_comb begin
    ram_we  = s1_vld_r & s1_ok_r;
    fwd     = wr_vld_r && (wr_addr_r == s1_slot_r);
    base    = s1_first_r ? '0 : (fwd ? wr_data_r : ram_rdata);
    sum_new = base + SUM_W'(s1_pix_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= 1'b0;
    end else begin
      wr_vld_r <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      wr_addr_r <= s1_slot_r;
      wr_data_r <= sum_new;
    end
  end

  // block mean into the beat buffer
  always_comb begin
    push            = ram_we & s1_last_r;
    push_beat.eof   = s1_eof_r;
    push_beat.eor   = s1_eor_r;
    push_beat.pixel = block_mean(sum_new, s1_lg_r);
  end

  bxavg_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_beat  (push_beat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_beat   (out_beat),
    .level      (fifo_level)
  );

  assign out_tdata = out_beat.pixel;
  assign out_tlast = out_beat.eor;
  assign out_tuser = out_beat.eof;

  // every accepted pixel reaches the update stage next cycle
  a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_vld_r)
    else $error("accepted pixel missing from update stage");

  // in-flight beats never exceed the buffer
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, fifo_level} + (FIFO_LVL_W + 1)'(s1_vld_r))
      <= (FIFO_LVL_W + 1)'(OUT_FIFO_DEPTH))
    else $error("more beats in flight than buffer room");

  // end of frame is always also end of row
  a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("end of frame without end of row");

  // position wraps to the origin after the last pixel of a frame
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_end) |=> ((col_r == '0) && (row_r == '0)))
    else $error("position not cleared at end of frame");

endmodule

// ===== rtl/core/bxavg_ram.sv =====
module bxavg_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bxavg_out_fifo.sv =====
module bxavg_out_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  bxavg_pkg::out_beat_t                push_beat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output bxavg_pkg::out_beat_t                out_beat,
  output logic [bxavg_pkg::FIFO_LVL_W-1:0]    level
);

  import bxavg_pkg::*;

  localparam int PW = $clog2(OUT_FIFO_DEPTH);

  out_beat_t             mem_r [OUT_FIFO_DEPTH];
  logic [PW-1:0]         wr_ptr_r;
  logic [PW-1:0]         rd_ptr_r;
  logic [FIFO_LVL_W-1:0] cnt_r;
  logic                  pop;

  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid & out_tready;
  assign out_beat   = mem_r[rd_ptr_r];
  assign level      = cnt_r;

  // beat storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_beat;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(OUT_FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(OUT_FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + FIFO_LVL_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - FIFO_LVL_W'(1);
      end
    end
  end

  // never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < FIFO_LVL_W'(OUT_FIFO_DEPTH)))
    else $error("beat buffer written while full");

  // level follows a lone push
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + FIFO_LVL_W'(1)))
    else $error("beat buffer level lost a push");

  // empty buffer has aligned pointers
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("beat buffer pointers drifted");

endmodule
